// ===== rtl/core/tpe_pkg.sv =====
// tpe_pkg: shared constants and sideband types for the track pT / eta pipeline.
// Used by tpe_sqrt_cell, tpe_log_cell and track_pt_eta. No dependencies.
package tpe_pkg;

  // input momentum components
  localparam int MOM_W         = 16;
  localparam int SQ_W          = 2 * MOM_W;
  // square roots carry ROOT_FRAC fraction bits
  localparam int ROOT_FRAC     = 32 - MOM_W;
  localparam int ROOT_W        = 32;
  localparam int RAD_W         = 2 * ROOT_W;
  localparam int REM_W         = ROOT_W + 2;
  // numerator (|z| << ROOT_FRAC) + p
  localparam int NUM_W         = ROOT_W + 1;
  // log2 datapath
  localparam int LOG_FRAC      = 20;
  localparam int MANT_FRAC     = 30;
  localparam int MANT_W        = MANT_FRAC + 1;
  localparam int EXP_W         = 6;
  localparam int LOG_W         = EXP_W + LOG_FRAC;
  localparam int NORM_W        = 64;
  // ln 2 in 32 fraction bits
  localparam int LN2_W         = 32;
  localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam int PROD_W        = LOG_W + LN2_W;
  // eta output
  localparam int ETA_FRAC_BITS = 10;
  localparam int RND_SH        = LOG_FRAC + LN2_W - ETA_FRAC_BITS;
  localparam int MAG_W         = PROD_W + 1 - RND_SH;
  localparam int ETA_W         = 14;
  localparam logic [ETA_W-1:0] ETA_LIMIT = 14'd8191;
  localparam int PT_W          = 16;

  // sideband through the square-root chain
  typedef struct packed {
    logic             zneg;
    logic             zzero;
    logic             stzero;
    logic [MOM_W-1:0] az;
  } front_sb_t;

  // sideband through the log chain and back end
  typedef struct packed {
    logic             zneg;
    logic             zzero;
    logic             stzero;
    logic [PT_W-1:0]  trans_mom;
    logic [EXP_W-1:0] n_num;
    logic [EXP_W-1:0] n_pt;
  } back_sb_t;

endpackage

// ===== rtl/core/tpe_sqrt_cell.sv =====
// tpe_sqrt_cell: one restoring square-root step, one root bit per cell.
// Depends on tpe_pkg for widths.
module tpe_sqrt_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tpe_pkg::RAD_W-1:0]    rad_in,
  input  logic [tpe_pkg::REM_W-1:0]    rem_in,
  input  logic [tpe_pkg::ROOT_W-1:0]   root_in,
  output logic [tpe_pkg::RAD_W-1:0]    rad_out,
  output logic [tpe_pkg::REM_W-1:0]    rem_out,
  output logic [tpe_pkg::ROOT_W-1:0]   root_out
);

  logic [tpe_pkg::REM_W+1:0] cand;
  logic [tpe_pkg::REM_W+1:0] sub;
  logic [tpe_pkg::REM_W+1:0] trial;
  logic                      fits;

  // bring down the next bit pair and try root*4+1
  always_comb begin
    cand  = {rem_in, rad_in[tpe_pkg::RAD_W-1 -: 2]};
    sub   = {2'b00, root_in, 2'b01};
    fits  = (cand >= sub);
    trial = cand - sub;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out <= {rad_in[tpe_pkg::RAD_W-3:0], 2'b00};
      if (fits) begin
        rem_out  <= trial[tpe_pkg::REM_W-1:0];
        root_out <= {root_in[tpe_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_out  <= cand[tpe_pkg::REM_W-1:0];
        root_out <= {root_in[tpe_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/tpe_log_cell.sv =====
// tpe_log_cell: one fraction bit of log2 by squaring the mantissa.
// Depends on tpe_pkg for widths.
module tpe_log_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tpe_pkg::MANT_W-1:0]    mant_in,
  input  logic [tpe_pkg::LOG_FRAC-1:0]  frac_in,
  output logic [tpe_pkg::MANT_W-1:0]    mant_out,
  output logic [tpe_pkg::LOG_FRAC-1:0]  frac_out
);

  logic [2*tpe_pkg::MANT_W-1:0] sq;
  logic [tpe_pkg::MANT_W:0]     sq_scaled;

  // square, back to 30 fraction bits
  always_comb begin
    sq        = mant_in * mant_in;
    sq_scaled = sq[2*tpe_pkg::MANT_W-1:tpe_pkg::MANT_FRAC];
  end

  // halve when the square reached 2, and emit a one
  always_ff @(posedge clk) begin
    if (en) begin
      if (sq_scaled[tpe_pkg::MANT_W]) begin
        mant_out <= sq_scaled[tpe_pkg::MANT_W:1];
        frac_out <= {frac_in[tpe_pkg::LOG_FRAC-2:0], 1'b1};
      end else begin
        mant_out <= sq_scaled[tpe_pkg::MANT_W-1:0];
        frac_out <= {frac_in[tpe_pkg::LOG_FRAC-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/track_pt_eta.sv =====
// track_pt_eta: transverse momentum and pseudorapidity of one track per beat.
// Depends on tpe_pkg, tpe_sqrt_cell, tpe_log_cell.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   input    | mom_valid, mom_stall | mom_x, mom_y, mom_z
//   output   | res_valid, res_stall | trans_mom, eta_value, eta_saturated
//
// One beat per cycle sustained while the skid is empty (mom_stall low).
// The pipeline depth comes from 32 square-root cells and 20 log2 cells in a row.
// rst clears all valid bits; datapath registers are not reset.
// The pipeline moves as a whole; a one-entry skid after the output register
// takes the beat in flight when res_stall rises, and mom_stall is that skid's fill.
module track_pt_eta (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              mom_valid,
  output logic                              mom_stall,
  input  logic signed [tpe_pkg::MOM_W-1:0]  mom_x,
  input  logic signed [tpe_pkg::MOM_W-1:0]  mom_y,
  input  logic signed [tpe_pkg::MOM_W-1:0]  mom_z,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic        [tpe_pkg::PT_W-1:0]   trans_mom,
  output logic signed [tpe_pkg::ETA_W-1:0]  eta_value,
  output logic                              eta_saturated
);

  localparam int SQ_STEPS  = tpe_pkg::ROOT_W;
  localparam int LOG_STEPS = tpe_pkg::LOG_FRAC;
  localparam int ST_SQRT0  = 2;
  localparam int ST_L0     = ST_SQRT0 + SQ_STEPS;
  localparam int ST_LOG0   = ST_L0 + 3;
  localparam int ST_F1     = ST_LOG0 + LOG_STEPS;
  localparam int NSTG      = ST_F1 + 3;
  localparam int FSB_N     = ST_L0;
  localparam int BSB_N     = 3 + LOG_STEPS + 2;
  localparam logic [tpe_pkg::LN2_W-1:0] LN2_PROD = tpe_pkg::LN2_Q32;

  logic en;
  logic take;
  logic [NSTG-1:0] vld;

  // skid stage
  logic                             skid_valid;
  logic [tpe_pkg::PT_W-1:0]         skid_trans;
  logic [tpe_pkg::ETA_W-1:0]        skid_eta;
  logic                             skid_sat;

  // front stages
  logic [tpe_pkg::MOM_W-1:0] ax, ay, az;
  logic [tpe_pkg::SQ_W-1:0]  sqx, sqy, sqz;
  logic [tpe_pkg::SQ_W-1:0]  st_sum, s_sum;
  tpe_pkg::front_sb_t        fsb [FSB_N];

  // square-root chains
  logic [tpe_pkg::RAD_W-1:0]  pt_rad  [SQ_STEPS+1];
  logic [tpe_pkg::REM_W-1:0]  pt_rem  [SQ_STEPS+1];
  logic [tpe_pkg::ROOT_W-1:0] pt_root [SQ_STEPS+1];
  logic [tpe_pkg::RAD_W-1:0]  p_rad   [SQ_STEPS+1];
  logic [tpe_pkg::REM_W-1:0]  p_rem   [SQ_STEPS+1];
  logic [tpe_pkg::ROOT_W-1:0] p_root  [SQ_STEPS+1];

  // log setup
  logic [tpe_pkg::NUM_W-1:0]  num0, num1;
  logic [tpe_pkg::ROOT_W-1:0] ptq0, ptq1;
  logic [tpe_pkg::PT_W:0]     tm_round;
  logic [tpe_pkg::EXP_W-1:0]  n_num_c, n_pt_c;
  logic [tpe_pkg::NORM_W-1:0] norm_num, norm_pt;
  tpe_pkg::back_sb_t          bsb [BSB_N];
  tpe_pkg::back_sb_t          bsb_l0;
  tpe_pkg::back_sb_t          bsb_l1;

  // log chains
  logic [tpe_pkg::MANT_W-1:0]   ln_m [LOG_STEPS+1];
  logic [tpe_pkg::LOG_FRAC-1:0] ln_f [LOG_STEPS+1];
  logic [tpe_pkg::MANT_W-1:0]   ld_m [LOG_STEPS+1];
  logic [tpe_pkg::LOG_FRAC-1:0] ld_f [LOG_STEPS+1];

  // back end
  logic [tpe_pkg::LOG_W-1:0]  log_num, log_pt;
  logic [tpe_pkg::LOG_W-1:0]  dlog;
  logic [tpe_pkg::PROD_W-1:0] prod;
  logic [tpe_pkg::PROD_W:0]   prod_rnd;
  logic [tpe_pkg::MAG_W-1:0]  mag_full;
  logic [tpe_pkg::ETA_W-1:0]  mag;
  logic                       sat;
  logic [tpe_pkg::ETA_W-1:0]  eta_c;
  logic [tpe_pkg::PT_W-1:0]   fin_trans;
  logic [tpe_pkg::ETA_W-1:0]  fin_eta;
  logic                       fin_sat;

  assign en        = !skid_valid;
  assign take      = res_valid && !res_stall;
  assign mom_stall = skid_valid;

  // stage valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], mom_valid};
    end
  end

  // stage 0: magnitudes and squares
  always_comb begin
    ax = mom_x[tpe_pkg::MOM_W-1] ? (~mom_x + 1'b1) : mom_x;
    ay = mom_y[tpe_pkg::MOM_W-1] ? (~mom_y + 1'b1) : mom_y;
    az = mom_z[tpe_pkg::MOM_W-1] ? (~mom_z + 1'b1) : mom_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx           <= ax * ax;
      sqy           <= ay * ay;
      sqz           <= az * az;
      fsb[0].zneg   <= mom_z[tpe_pkg::MOM_W-1];
      fsb[0].zzero  <= (mom_z == '0);
      fsb[0].stzero <= (mom_x == '0) && (mom_y == '0);
      fsb[0].az     <= az;
    end
  end

  // stage 1: sums of squares
  always_ff @(posedge clk) begin
    if (en) begin
      st_sum <= sqx + sqy;
      s_sum  <= sqx + sqy + sqz;
      fsb[1] <= fsb[0];
    end
  end

  // sideband alongside the root cells
  for (genvar i = 2; i < FSB_N; i++) begin : g_fsb
    always_ff @(posedge clk) begin
      if (en) begin
        fsb[i] <= fsb[i-1];
      end
    end
  end

  // square-root chains: floor(sqrt(v << 2*ROOT_FRAC))
  assign pt_rad[0]  = {st_sum, {(tpe_pkg::RAD_W-tpe_pkg::SQ_W){1'b0}}};
  assign pt_rem[0]  = '0;
  assign pt_root[0] = '0;
  assign p_rad[0]   = {s_sum, {(tpe_pkg::RAD_W-tpe_pkg::SQ_W){1'b0}}};
  assign p_rem[0]   = '0;
  assign p_root[0]  = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    tpe_sqrt_cell u_pt (
      .clk      (clk),
      .en       (en),
      .rad_in   (pt_rad[k]),
      .rem_in   (pt_rem[k]),
      .root_in  (pt_root[k]),
      .rad_out  (pt_rad[k+1]),
      .rem_out  (pt_rem[k+1]),
      .root_out (pt_root[k+1])
    );
    tpe_sqrt_cell u_p (
      .clk      (clk),
      .en       (en),
      .rad_in   (p_rad[k]),
      .rem_in   (p_rem[k]),
      .root_in  (p_root[k]),
      .rad_out  (p_rad[k+1]),
      .rem_out  (p_rem[k+1]),
      .root_out (p_root[k+1])
    );
  end

  // L0: numerator and rounded pT
  always_comb begin
    tm_round            = (tpe_pkg::PT_W+1)'(({1'b0, pt_root[SQ_STEPS]}
                          + (33'd1 << (tpe_pkg::ROOT_FRAC - 1))) >> tpe_pkg::ROOT_FRAC);
    bsb_l0.zneg         = fsb[FSB_N-1].zneg;
    bsb_l0.zzero        = fsb[FSB_N-1].zzero;
    bsb_l0.stzero       = fsb[FSB_N-1].stzero;
    bsb_l0.trans_mom    = tm_round[tpe_pkg::PT_W] ? '1 : tm_round[tpe_pkg::PT_W-1:0];
    bsb_l0.n_num        = '0;
    bsb_l0.n_pt         = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0   <= ({{(tpe_pkg::NUM_W-tpe_pkg::MOM_W){1'b0}}, fsb[FSB_N-1].az}
                 << tpe_pkg::ROOT_FRAC) + {1'b0, p_root[SQ_STEPS]};
      ptq0   <= pt_root[SQ_STEPS];
      bsb[0] <= bsb_l0;
    end
  end

  // L1: leading-one positions
  always_comb begin
    n_num_c = '0;
    n_pt_c  = '0;
    for (int i = 0; i < tpe_pkg::NUM_W; i++) begin
      if (num0[i]) n_num_c = tpe_pkg::EXP_W'(i);
    end
    for (int i = 0; i < tpe_pkg::ROOT_W; i++) begin
      if (ptq0[i]) n_pt_c = tpe_pkg::EXP_W'(i);
    end
    bsb_l1       = bsb[0];
    bsb_l1.n_num = n_num_c;
    bsb_l1.n_pt  = n_pt_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1   <= num0;
      ptq1   <= ptq0;
      bsb[1] <= bsb_l1;
    end
  end

  // L2: normalize mantissas to 1.30
  always_comb begin
    norm_num = ({{(tpe_pkg::NORM_W-tpe_pkg::NUM_W){1'b0}}, num1} << tpe_pkg::MANT_FRAC)
               >> bsb[1].n_num;
    norm_pt  = ({{(tpe_pkg::NORM_W-tpe_pkg::ROOT_W){1'b0}}, ptq1} << tpe_pkg::MANT_FRAC)
               >> bsb[1].n_pt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln_m[0] <= norm_num[tpe_pkg::MANT_W-1:0];
      ld_m[0] <= norm_pt[tpe_pkg::MANT_W-1:0];
      bsb[2]  <= bsb[1];
    end
  end

  assign ln_f[0] = '0;
  assign ld_f[0] = '0;

  // log2 chains
  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
    tpe_log_cell u_num (
      .clk      (clk),
      .en       (en),
      .mant_in  (ln_m[k]),
      .frac_in  (ln_f[k]),
      .mant_out (ln_m[k+1]),
      .frac_out (ln_f[k+1])
    );
    tpe_log_cell u_pt (
      .clk      (clk),
      .en       (en),
      .mant_in  (ld_m[k]),
      .frac_in  (ld_f[k]),
      .mant_out (ld_m[k+1]),
      .frac_out (ld_f[k+1])
    );
  end

  // sideband alongside the log cells and the back end
  for (genvar i = 3; i < BSB_N; i++) begin : g_bsb
    always_ff @(posedge clk) begin
      if (en) begin
        bsb[i] <= bsb[i-1];
      end
    end
  end

  // F1: log difference, clamped at zero
  assign log_num = {bsb[2+LOG_STEPS].n_num, ln_f[LOG_STEPS]};
  assign log_pt  = {bsb[2+LOG_STEPS].n_pt, ld_f[LOG_STEPS]};

  always_ff @(posedge clk) begin
    if (en) begin
      dlog <= (log_num > log_pt) ? (log_num - log_pt) : '0;
    end
  end

  // F2: scale by ln 2
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= dlog * LN2_PROD;
    end
  end

  // F3: round, clip, special cases, sign
  always_comb begin
    prod_rnd = {1'b0, prod} + ((tpe_pkg::PROD_W+1)'(1) << (tpe_pkg::RND_SH - 1));
    mag_full = prod_rnd[tpe_pkg::PROD_W:tpe_pkg::RND_SH];
    if (bsb[BSB_N-1].zzero) begin
      mag = '0;
      sat = bsb[BSB_N-1].stzero;
    end else if (bsb[BSB_N-1].stzero) begin
      mag = tpe_pkg::ETA_LIMIT;
      sat = 1'b1;
    end else if (mag_full > tpe_pkg::MAG_W'(tpe_pkg::ETA_LIMIT)) begin
      mag = tpe_pkg::ETA_LIMIT;
      sat = 1'b1;
    end else begin
      mag = mag_full[tpe_pkg::ETA_W-1:0];
      sat = 1'b0;
    end
    eta_c = bsb[BSB_N-1].zneg ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_trans <= bsb[BSB_N-1].trans_mom;
      fin_eta   <= eta_c;
      fin_sat   <= sat;
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en && vld[NSTG-1]) begin
      if (!res_valid || take) begin
        res_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[NSTG-1]) begin
      if (!res_valid || take) begin
        trans_mom     <= fin_trans;
        eta_value     <= fin_eta;
        eta_saturated <= fin_sat;
      end else begin
        skid_trans <= fin_trans;
        skid_eta   <= fin_eta;
        skid_sat   <= fin_sat;
      end
    end else if (take && skid_valid) begin
      trans_mom     <= skid_trans;
      eta_value     <= skid_eta;
      eta_saturated <= skid_sat;
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid holds a beat while output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(res_valid && res_stall))
    else $error("skid filled without a stalled output");

  a_eta_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (eta_value != {1'b1, {(tpe_pkg::ETA_W-1){1'b0}}}))
    else $error("eta outside saturation range");

  a_zero_pt_sat: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (trans_mom == '0)) |-> eta_saturated)
    else $error("zero pT without saturation flag");

endmodule
